### rtl/gcba_pkg.sv
// Shared types and constants for the grid cell binning averager.
// Request, response and memory entry structs, request kinds, CSR indexes.
// No dependencies.
package gcba_pkg;

   localparam int SUM_W   = 56;
   localparam int COUNT_W = 24;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;

   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_CELL_DX  = 3'd3;
   localparam logic [2:0] CSR_CELL_DY  = 3'd4;
   localparam logic [2:0] CSR_CELL_DZ  = 3'd5;
   localparam logic [2:0] CSR_CELLS_X  = 3'd6;
   localparam logic [2:0] CSR_CELLS_Y  = 3'd7;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] mid_x;
      logic signed [31:0] mid_y;
      logic signed [31:0] mid_z;
      logic [31:0]        size_value;
      logic [11:0]        cell_index;
   } req_type;

   typedef struct packed {
      logic [31:0]        mean_size;
      logic               used_fill;
      logic [COUNT_W-1:0] elements_in_cell;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } cell_entry_type;

endpackage

### rtl/grid_cell_binning_averager_unit.sv
// Top level of the grid cell binning averager: sequencer, cell memory, shared divider.
// Depends on gcba_pkg.
//
//  channel   ports                               handshake
//  -------   ---------------------------------   ---------------------------------
//  request   start, busy, req_data               taken when start && !busy
//  response  rsp_valid, rsp_data                 one-cycle strobe, cannot be stalled
//  csr       csr_valid, csr_ready, csr_index,    written when csr_valid && csr_ready
//            csr_wdata
//
// Add request: while busy it runs three 32-step divisions on one shared restoring
// divider (one quotient bit a cycle), two multiply stages, an index stage and a
// read-modify-write of the cell memory. Read request: the response strobes without
// a division for an empty grid, else after a 56-step mean division. Clear request:
// busy until every memory entry is zeroed, one memory entry a cycle. After reset the
// same clearing pass runs with busy high; CSR writes are taken at all times. Responses
// leave on a one-cycle strobe; the receiver cannot stall them.
module grid_cell_binning_averager_unit #(
   parameter int GRID_CELLS = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gcba_pkg::req_type req_data,
   output logic             rsp_valid,
   output gcba_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import gcba_pkg::*;

   localparam int AW = $clog2(GRID_CELLS);
   localparam logic [AW-1:0] LAST_CELL = AW'(GRID_CELLS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_DIVX, S_DIVY, S_DIVZ, S_MUL1, S_MUL2, S_LIN,
      S_ADD_RD, S_ADD_WR, S_RD_RD, S_RD_EVAL, S_MEAN
   } state_type;

   // configuration
   logic signed [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [30:0]        cell_dx_ff, cell_dy_ff, cell_dz_ff;
   logic [12:0]        cells_x_ff, cells_y_ff;

   // sequencer
   state_type          state_ff;
   req_type            req_ff;
   logic [AW-1:0]      addr_ff;
   logic [31:0]        xi_ff, yi_ff, zi_ff;
   logic [44:0]        p1_ff;
   logic [25:0]        nn_ff;
   logic [57:0]        p2_ff;
   logic [SUM_W-1:0]   total_sum_ff;
   logic [COUNT_W-1:0] total_count_ff;
   logic               rsp_valid_ff;
   logic               rsp_fire;
   rsp_type            rsp_ff;

   // divider
   logic [55:0]        div_q_ff;
   logic [31:0]        div_r_ff;
   logic [30:0]        div_d_ff;
   logic [5:0]         div_cnt_ff;
   logic [31:0]        div_shift;
   logic               div_ge;
   logic [31:0]        div_r_in;
   logic [55:0]        div_q_in;

   // memory
   cell_entry_type     mem [GRID_CELLS];
   cell_entry_type     rdata_ff;
   logic               mem_we;
   cell_entry_type     mem_wdata;

   // axis operands
   logic [31:0]        dm1_x, dm1_y, dm1_z;
   logic [30:0]        div_cx, div_cy, div_cz;
   logic [58:0]        lin;
   logic [AW-1:0]      lin_idx, rd_idx;
   cell_entry_type     upd;

   // Offset minus one along an axis; zero when the point is not past the origin.
   function automatic logic [31:0] axis_dm1(input logic signed [31:0] p,
                                            input logic signed [31:0] o);
      logic signed [32:0] d;
      logic [32:0]        dm;
      d  = 33'($signed(p)) - 33'($signed(o));
      dm = 33'(d) - 33'd1;
      if (d[32] || d == 33'sd0) return 32'd0;
      return dm[31:0];
   endfunction

   assign dm1_x  = axis_dm1(req_ff.mid_x, origin_x_ff);
   assign dm1_y  = axis_dm1(req_ff.mid_y, origin_y_ff);
   assign dm1_z  = axis_dm1(req_ff.mid_z, origin_z_ff);
   assign div_cx = (cell_dx_ff == '0) ? 31'd1 : cell_dx_ff;
   assign div_cy = (cell_dy_ff == '0) ? 31'd1 : cell_dy_ff;
   assign div_cz = (cell_dz_ff == '0) ? 31'd1 : cell_dz_ff;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign div_shift = {div_r_ff[30:0], div_q_ff[55]};
   assign div_ge    = div_shift >= {1'b0, div_d_ff};
   assign div_r_in  = div_ge ? (div_shift - {1'b0, div_d_ff}) : div_shift;
   assign div_q_in  = {div_q_ff[54:0], div_ge};

   // Exact linear index, saturated at the last cell.
   assign lin     = 59'(xi_ff) + 59'(p1_ff) + 59'(p2_ff);
   assign lin_idx = (lin >= 59'(GRID_CELLS)) ? LAST_CELL : lin[AW-1:0];
   assign rd_idx  = ({20'd0, req_data.cell_index} >= 32'(GRID_CELLS)) ? LAST_CELL
                                                                       : AW'(req_data.cell_index);

   // Raise the strobe when the mean division ends or the grid holds nothing.
   assign rsp_fire = ((state_ff == S_MEAN) && (div_cnt_ff == 6'd1)) ||
                     ((state_ff == S_RD_EVAL) && (rdata_ff.count == '0) &&
                      (total_count_ff == '0));

   // Cell update: a full count drops further adds.
   always_comb begin
      upd = rdata_ff;
      if (rdata_ff.count != COUNT_MAX) begin
         upd.sum   = rdata_ff.sum + SUM_W'(req_ff.size_value);
         upd.count = rdata_ff.count + COUNT_W'(1);
      end
   end

   assign mem_we    = (state_ff == S_CLR) || (state_ff == S_ADD_WR);
   assign mem_wdata = (state_ff == S_CLR) ? '0 : upd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   // CSR writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         cell_dx_ff  <= 31'd65536;
         cell_dy_ff  <= 31'd65536;
         cell_dz_ff  <= 31'd65536;
         cells_x_ff  <= 13'd16;
         cells_y_ff  <= 13'd16;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            CSR_CELL_DX:  cell_dx_ff  <= csr_wdata[30:0];
            CSR_CELL_DY:  cell_dy_ff  <= csr_wdata[30:0];
            CSR_CELL_DZ:  cell_dz_ff  <= csr_wdata[30:0];
            CSR_CELLS_X:  cells_x_ff  <= csr_wdata[12:0];
            CSR_CELLS_Y:  cells_y_ff  <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Sequencer with registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         state_ff       <= S_CLR;
         addr_ff        <= '0;
         total_sum_ff   <= '0;
         total_count_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_fire;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  case (req_data.kind)
                     KIND_ADD:   state_ff <= S_DIVX;
                     KIND_READ: begin
                        addr_ff  <= rd_idx;
                        state_ff <= S_RD_RD;
                     end
                     KIND_CLEAR: begin
                        addr_ff        <= '0;
                        total_sum_ff   <= '0;
                        total_count_ff <= '0;
                        state_ff       <= S_CLR;
                     end
                     default: ;  // unused kind: drop
                  endcase
                  // Load the x division; harmless for other kinds.
                  div_q_ff   <= {axis_dm1(req_data.mid_x, origin_x_ff), 24'd0};
                  div_r_ff   <= '0;
                  div_d_ff   <= div_cx;
                  div_cnt_ff <= 6'd32;
               end
            end
            S_CLR: begin
               addr_ff <= addr_ff + AW'(1);
               if (addr_ff == LAST_CELL) state_ff <= S_IDLE;
            end
            S_DIVX, S_DIVY, S_DIVZ, S_MEAN: begin
               if (div_cnt_ff != 6'd1) begin
                  div_q_ff   <= div_q_in;
                  div_r_ff   <= div_r_in;
                  div_cnt_ff <= div_cnt_ff - 6'd1;
               end else begin
                  div_r_ff   <= '0;
                  div_cnt_ff <= 6'd32;
                  case (state_ff)
                     S_DIVX: begin
                        xi_ff    <= div_q_in[31:0];
                        div_q_ff <= {dm1_y, 24'd0};
                        div_d_ff <= div_cy;
                        state_ff <= S_DIVY;
                     end
                     S_DIVY: begin
                        yi_ff    <= div_q_in[31:0];
                        div_q_ff <= {dm1_z, 24'd0};
                        div_d_ff <= div_cz;
                        state_ff <= S_DIVZ;
                     end
                     S_DIVZ: begin
                        zi_ff    <= div_q_in[31:0];
                        state_ff <= S_MUL1;
                     end
                     default: begin
                        rsp_ff.mean_size <= div_q_in[31:0];
                        state_ff         <= S_IDLE;
                     end
                  endcase
               end
            end
            S_MUL1: begin
               p1_ff    <= yi_ff * cells_x_ff;
               nn_ff    <= cells_x_ff * cells_y_ff;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               p2_ff    <= zi_ff * nn_ff;
               state_ff <= S_LIN;
            end
            S_LIN: begin
               addr_ff  <= lin_idx;
               state_ff <= S_ADD_RD;
            end
            S_ADD_RD: state_ff <= S_ADD_WR;
            S_ADD_WR: begin
               if (total_count_ff != COUNT_MAX) begin
                  total_sum_ff   <= total_sum_ff + SUM_W'(req_ff.size_value);
                  total_count_ff <= total_count_ff + COUNT_W'(1);
               end
               state_ff <= S_IDLE;
            end
            S_RD_RD: state_ff <= S_RD_EVAL;
            S_RD_EVAL: begin
               rsp_ff.elements_in_cell <= rdata_ff.count;
               div_r_ff   <= '0;
               div_cnt_ff <= 6'd56;
               if (rdata_ff.count != '0) begin
                  rsp_ff.used_fill <= 1'b0;
                  div_q_ff         <= rdata_ff.sum;
                  div_d_ff         <= 31'(rdata_ff.count);
                  state_ff         <= S_MEAN;
               end else if (total_count_ff != '0) begin
                  rsp_ff.used_fill <= 1'b1;
                  div_q_ff         <= total_sum_ff;
                  div_d_ff         <= 31'(total_count_ff);
                  state_ff         <= S_MEAN;
               end else begin
                  // empty grid: mean zero straight away
                  rsp_ff.used_fill <= 1'b1;
                  rsp_ff.mean_size <= '0;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/gcba_checker.sv
// Port-level checks for the grid cell binning averager.
// Depends on gcba_pkg; bound to grid_cell_binning_averager_unit below.
module gcba_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input gcba_pkg::req_type req_data,
   input logic              rsp_valid,
   input gcba_pkg::rsp_type rsp_data
);
   import gcba_pkg::*;

   // Reset always starts the clearing pass.
   a_reset_clears: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_add_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.kind == KIND_ADD || req_data.kind == KIND_CLEAR)) |=> busy)
      else $error("add or clear request did not occupy the block");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   a_fill_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.elements_in_cell == '0) |-> rsp_data.used_fill)
      else $error("empty cell reported without fill");

   a_fill_only_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.used_fill) |-> rsp_data.elements_in_cell == '0)
      else $error("fill flagged on occupied cell");

endmodule

bind grid_cell_binning_averager_unit gcba_checker u_gcba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
